@@ hdl/knn_top5_majority_classifier_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the nearest-neighbor classifier
// Shared property wrappers clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef KNN_TOP5_MAJORITY_CLASSIFIER_ASSERT_SVH
`define KNN_TOP5_MAJORITY_CLASSIFIER_ASSERT_SVH

// Checks that a property holds at every rising clock edge.
`define KNN_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("knn assertion failed");

// Checks that a consequence holds in the cycle after its cause.
`define KNN_ASSERT_NEXT(name, cause, effect) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |=> (effect)) \
    else $error("knn assertion failed");

`endif

@@ hdl/knn_pkg.sv @@
// ---------------------------------------------------------------------------
// Nearest-neighbor classifier package
// Shared types and constants for the classifier, its cells and its vote unit.
// ---------------------------------------------------------------------------
package knn_pkg;

  localparam int unsigned DistW     = 48;
  localparam int unsigned LabelW    = 10;
  localparam int unsigned DimW      = 11;
  localparam int unsigned ValueW    = 16;
  localparam int unsigned SqW       = 34;
  localparam int unsigned ClassW    = 11;
  localparam int unsigned MinVotesW = 3;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [DistW-1:0]     DistMax        = '1;
  localparam logic [DistW-1:0]     ThresholdReset = 48'd2415919104;
  localparam logic [MinVotesW-1:0] MinVotesReset  = 3'd2;

  localparam logic CmdQuery = 1'b0;
  localparam logic CmdRef   = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 2'd0,
    CfgMinVotes  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic                     command;
    logic [DimW-1:0]          dim_index;
    logic signed [ValueW-1:0] value;
    logic [LabelW-1:0]        label;
    logic                     row_last;
    logic                     set_last;
  } in_t;

  typedef struct packed {
    logic signed [ClassW-1:0] class_id;
    logic [DistW-1:0]         score;
    logic                     found;
  } out_t;

  typedef struct packed {
    logic              filled;
    logic [DistW-1:0]  distance;
    logic [LabelW-1:0] label;
  } slot_t;

  typedef struct packed {
    logic [DistW-1:0]  distance;
    logic [LabelW-1:0] label;
    logic              set_end;
  } row_t;

  localparam slot_t SlotEmpty = '{filled: 1'b0, distance: DistMax, label: '0};

endpackage

@@ hdl/knn_top5_majority_classifier.sv @@
// ---------------------------------------------------------------------------
// Nearest-neighbor classifier with majority vote
// Streams reference rows against a stored query and votes among the nearest.
// ---------------------------------------------------------------------------
// Channel  Direction  Signals
// in       input      in_valid_i, in_ready_o, in_i
// out      output     out_valid_o, out_ready_i, out_o
// cfg      input      cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//
// One input beat is taken every cycle while not stalled; the query store read,
// the multiplier and the neighbor chain each take one stage.
// The result of a set passes the row, snapshot, vote and output registers.
// Reset empties the neighbor list; the query store is not cleared.
// Input stalls only while a finished result waits and the output is full.
// ---------------------------------------------------------------------------
`include "knn_top5_majority_classifier_assert.svh"

module knn_top5_majority_classifier #(
  parameter int unsigned NEIGHBORS      = 5,
  parameter int unsigned MAX_DIMENSIONS = 2048,
  parameter int unsigned LABEL_COUNT    = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  knn_pkg::in_t                    in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output knn_pkg::out_t                   out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [knn_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [knn_pkg::DistW-1:0]       cfg_data_i
);

  localparam int unsigned AddrW = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;

  logic [knn_pkg::DistW-1:0]     thr_q;
  logic [knn_pkg::MinVotesW-1:0] mv_q;

  logic stall;
  logic en;
  logic accept;
  logic in_range;
  logic [AddrW-1:0] addr;
  logic [knn_pkg::LabelW-1:0] label_sat;

  logic [knn_pkg::ValueW-1:0] qmem [MAX_DIMENSIONS];
  logic signed [knn_pkg::ValueW-1:0] q_rd_q;

  logic                              p1_valid_q;
  logic signed [knn_pkg::ValueW-1:0] p1_value_q;
  logic                              p1_inr_q;
  logic [knn_pkg::LabelW-1:0]        p1_label_q;
  logic                              p1_row_end_q;
  logic                              p1_set_end_q;

  logic signed [knn_pkg::ValueW:0]   diff;
  logic signed [knn_pkg::SqW-1:0]    prod;
  logic                              p2_valid_q;
  logic [knn_pkg::SqW-1:0]           p2_sq_q;
  logic [knn_pkg::LabelW-1:0]        p2_label_q;
  logic                              p2_row_end_q;
  logic                              p2_set_end_q;

  logic [knn_pkg::DistW-1:0] acc_q;
  logic [knn_pkg::DistW:0]   sum;
  logic [knn_pkg::DistW-1:0] sum_sat;
  logic                      r_valid_q;
  knn_pkg::row_t             r_q;

  knn_pkg::slot_t slot   [NEIGHBORS];
  knn_pkg::slot_t slot_d [NEIGHBORS];
  logic           less   [NEIGHBORS];

  logic           snap_valid_q;
  knn_pkg::slot_t snap_q [NEIGHBORS];

  logic           res_valid;
  knn_pkg::out_t  res;
  logic           out_valid_q;
  knn_pkg::out_t  out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= knn_pkg::ThresholdReset;
      mv_q  <= knn_pkg::MinVotesReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        knn_pkg::CfgThreshold: thr_q <= cfg_data_i;
        knn_pkg::CfgMinVotes:  mv_q  <= cfg_data_i[knn_pkg::MinVotesW-1:0];
        default: ;
      endcase
    end
  end

  assign stall      = res_valid && out_valid_q && !out_ready_i;
  assign en         = !stall;
  assign in_ready_o = en;
  assign accept     = in_valid_i && in_ready_o;

  assign in_range  = 13'(in_i.dim_index) < 13'(MAX_DIMENSIONS);
  assign addr      = AddrW'(in_i.dim_index);
  assign label_sat = (17'(in_i.label) >= 17'(LABEL_COUNT)) ?
                     knn_pkg::LabelW'(LABEL_COUNT - 1) : in_i.label;

  always_ff @(posedge clk_i) begin
    if (accept && (in_i.command == knn_pkg::CmdQuery) && in_range) begin
      qmem[addr] <= in_i.value;
    end
    if (en) begin
      q_rd_q <= qmem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      r_valid_q  <= 1'b0;
      acc_q      <= '0;
    end else if (en) begin
      p1_valid_q <= accept && (in_i.command == knn_pkg::CmdRef);
      p2_valid_q <= p1_valid_q;
      r_valid_q  <= p2_valid_q && p2_row_end_q;
      if (p2_valid_q) begin
        acc_q <= p2_row_end_q ? '0 : sum_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_value_q   <= in_i.value;
      p1_inr_q     <= in_range;
      p1_label_q   <= label_sat;
      p1_row_end_q <= in_i.row_last || in_i.set_last;
      p1_set_end_q <= in_i.set_last;
      p2_sq_q      <= p1_inr_q ? knn_pkg::SqW'(prod) : '0;
      p2_label_q   <= p1_label_q;
      p2_row_end_q <= p1_row_end_q;
      p2_set_end_q <= p1_set_end_q;
      r_q          <= '{distance: sum_sat, label: p2_label_q, set_end: p2_set_end_q};
    end
  end

  assign diff    = (knn_pkg::ValueW+1)'(p1_value_q) - (knn_pkg::ValueW+1)'(q_rd_q);
  assign prod    = knn_pkg::SqW'(diff * diff);
  assign sum     = {1'b0, acc_q} + (knn_pkg::DistW+1)'(p2_sq_q);
  assign sum_sat = sum[knn_pkg::DistW] ? knn_pkg::DistMax : sum[knn_pkg::DistW-1:0];

  for (genvar i = 0; i < NEIGHBORS; i++) begin : g_cell
    knn_pkg::slot_t left;
    logic           left_less;
    if (i == 0) begin : g_head
      assign left      = knn_pkg::SlotEmpty;
      assign left_less = 1'b0;
    end else begin : g_body
      assign left      = slot[i-1];
      assign left_less = less[i-1];
    end
    knn_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .row_valid_i (r_valid_q),
      .clear_i     (r_valid_q && r_q.set_end),
      .row_i       (r_q),
      .left_i      (left),
      .left_less_i (left_less),
      .slot_o      (slot[i]),
      .slot_d_o    (slot_d[i]),
      .less_o      (less[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (en) begin
      snap_valid_q <= r_valid_q && r_q.set_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && r_valid_q && r_q.set_end) begin
      snap_q <= slot_d;
    end
  end

  knn_vote #(
    .Neighbors (NEIGHBORS)
  ) u_vote (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (snap_valid_q),
    .slots_i     (snap_q),
    .threshold_i (thr_q),
    .min_votes_i (mv_q),
    .valid_o     (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready_i || !out_valid_q) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_valid_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  for (genvar i = 1; i < NEIGHBORS; i++) begin : g_chk
    `KNN_ASSERT(a_filled_prefix, !slot[i].filled || slot[i-1].filled)
    `KNN_ASSERT(a_sorted, !slot[i].filled || (slot[i-1].distance <= slot[i].distance))
  end
  `KNN_ASSERT(a_found_class, !(out_valid_o && out_o.found) || !out_o.class_id[10])
  `KNN_ASSERT_NEXT(a_clear_after_set, en && r_valid_q && r_q.set_end, !slot[0].filled)

endmodule

@@ hdl/knn_cell.sv @@
// ---------------------------------------------------------------------------
// Neighbor cell
// One slot of the sorted neighbor list; takes a new row or its left neighbor, else holds.
// ---------------------------------------------------------------------------
module knn_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           row_valid_i,
  input  logic           clear_i,
  input  knn_pkg::row_t  row_i,
  input  knn_pkg::slot_t left_i,
  input  logic           left_less_i,
  output knn_pkg::slot_t slot_o,
  output knn_pkg::slot_t slot_d_o,
  output logic           less_o
);

  knn_pkg::slot_t slot_q;
  knn_pkg::slot_t slot_d;

  assign less_o = row_valid_i && (!slot_q.filled || (row_i.distance < slot_q.distance));

  always_comb begin
    if (left_less_i) begin
      slot_d = left_i;
    end else if (less_o) begin
      slot_d = '{filled: 1'b1, distance: row_i.distance, label: row_i.label};
    end else begin
      slot_d = slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= knn_pkg::SlotEmpty;
    end else if (en_i) begin
      slot_q <= clear_i ? knn_pkg::SlotEmpty : slot_d;
    end
  end

  assign slot_o   = slot_q;
  assign slot_d_o = slot_d;

endmodule

@@ hdl/knn_vote.sv @@
// ---------------------------------------------------------------------------
// Majority vote unit
// Three stages: vote counts, winner selection, threshold check and score.
// ---------------------------------------------------------------------------
module knn_vote #(
  parameter int unsigned Neighbors = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  knn_pkg::slot_t                    slots_i [Neighbors],
  input  logic [knn_pkg::DistW-1:0]         threshold_i,
  input  logic [knn_pkg::MinVotesW-1:0]     min_votes_i,
  output logic                              valid_o,
  output knn_pkg::out_t                     res_o
);

  localparam int unsigned VoteW = $clog2(Neighbors + 1);
  localparam int unsigned CmpW  = (VoteW > knn_pkg::MinVotesW) ? VoteW : knn_pkg::MinVotesW;

  logic                  s1_valid_q;
  knn_pkg::slot_t        s1_slots_q [Neighbors];
  logic [VoteW-1:0]      s1_votes_q [Neighbors];
  logic                  s1_near_q;
  logic [VoteW-1:0]      votes_c [Neighbors];

  logic                         s2_valid_q;
  knn_pkg::slot_t               s2_slots_q [Neighbors];
  logic                         s2_near_q;
  logic [VoteW-1:0]             s2_best_q;
  logic [knn_pkg::LabelW-1:0]   s2_win_q;
  logic [VoteW-1:0]             best_c;
  logic [knn_pkg::LabelW-1:0]   win_c;

  logic                         s3_valid_q;
  knn_pkg::out_t                s3_res_q;
  knn_pkg::out_t                res_c;
  logic [CmpW-1:0]              need_c;
  logic                         ok_c;
  logic                         hit_c;
  logic [knn_pkg::DistW-1:0]    score_c;

  always_comb begin
    for (int i = 0; i < Neighbors; i++) begin
      votes_c[i] = '0;
      for (int m = 0; m < Neighbors; m++) begin
        if (slots_i[m].filled && (slots_i[m].label == slots_i[i].label)) begin
          votes_c[i] = votes_c[i] + VoteW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_slots_q <= slots_i;
      s1_votes_q <= votes_c;
      s1_near_q  <= slots_i[0].filled && (slots_i[0].distance < threshold_i);
    end
  end

  always_comb begin
    best_c = '0;
    win_c  = '0;
    for (int i = 0; i < Neighbors; i++) begin
      if (s1_slots_q[i].filled && ((s1_votes_q[i] > best_c) ||
          ((s1_votes_q[i] == best_c) && (s1_slots_q[i].label < win_c)))) begin
        best_c = s1_votes_q[i];
        win_c  = s1_slots_q[i].label;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_slots_q <= s1_slots_q;
      s2_near_q  <= s1_near_q;
      s2_best_q  <= best_c;
      s2_win_q   <= win_c;
    end
  end

  always_comb begin
    need_c  = (min_votes_i == '0) ? CmpW'(1) : CmpW'(min_votes_i);
    ok_c    = s2_near_q && (CmpW'(s2_best_q) >= need_c);
    hit_c   = 1'b0;
    score_c = '0;
    for (int i = 0; i < Neighbors; i++) begin
      if (!hit_c && s2_slots_q[i].filled && (s2_slots_q[i].label == s2_win_q)) begin
        hit_c   = 1'b1;
        score_c = s2_slots_q[i].distance;
      end
    end
    res_c.class_id = ok_c ? {1'b0, s2_win_q} : '1;
    res_c.score    = ok_c ? score_c : '0;
    res_c.found    = ok_c;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_res_q <= res_c;
    end
  end

  assign valid_o = s3_valid_q;
  assign res_o   = s3_res_q;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the nearest-neighbor classifier
// Loads query vectors, streams labelled reference rows and checks each class
// decision against a predictor of the five-nearest majority vote.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned NumNear = 5;
  localparam int unsigned NumDims = 2048;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  knn_pkg::in_t in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  knn_pkg::out_t out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [knn_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [knn_pkg::DistW-1:0] cfg_data_i = '0;

  knn_top5_majority_classifier dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state.
  logic [knn_pkg::DistW-1:0] thr_q = knn_pkg::ThresholdReset;
  logic [knn_pkg::MinVotesW-1:0] votes_q = knn_pkg::MinVotesReset;
  logic signed [knn_pkg::ValueW-1:0] query_mem[NumDims];
  logic [knn_pkg::DistW-1:0] acc_q;
  logic [knn_pkg::DistW-1:0] near_dist[NumNear];
  logic [knn_pkg::LabelW-1:0] near_lab[NumNear];
  int unsigned near_cnt;

  knn_pkg::out_t class_q[$];
  int unsigned errors = 0;
  int unsigned results = 0;
  int unsigned beats = 0;
  bit hold_off = 1'b0;
  int unsigned hold_cnt = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("Mismatch on %s: got %0h, expected %0h (result %0d)", what, got, want, results);
    errors++;
  endtask

  function automatic void clear_near();
    for (int i = 0; i < NumNear; i++) begin
      near_dist[i] = knn_pkg::DistMax;
      near_lab[i] = '0;
    end
    near_cnt = 0;
    acc_q = '0;
  endfunction

  function automatic knn_pkg::out_t vote_class();
    knn_pkg::out_t r;
    int unsigned best = 0;
    int unsigned v;
    int unsigned need;
    logic [knn_pkg::LabelW-1:0] win;
    r = '{class_id: -11'sd1, score: '0, found: 1'b0};
    need = (votes_q == 0) ? 1 : votes_q;
    win = '0;
    if (near_cnt > 0 && near_dist[0] < thr_q) begin
      for (int i = 0; i < near_cnt; i++) begin
        v = 0;
        for (int m = 0; m < near_cnt; m++) if (near_lab[m] == near_lab[i]) v++;
        if (v > best || (v == best && near_lab[i] < win)) begin
          best = v;
          win = near_lab[i];
        end
      end
      if (best >= need) begin
        r.class_id = {1'b0, win};
        r.found = 1'b1;
        for (int i = near_cnt - 1; i >= 0; i--) if (near_lab[i] == win) r.score = near_dist[i];
      end
    end
    return r;
  endfunction

  function automatic void predict_beat(input knn_pkg::in_t b);
    logic signed [17:0] d;
    logic [48:0] sum;
    int unsigned j;
    int unsigned k;
    if (b.command == knn_pkg::CmdQuery) begin
      query_mem[b.dim_index] = b.value;
      return;
    end
    d = 18'(b.value) - 18'(query_mem[b.dim_index]);
    sum = {1'b0, acc_q} + 49'(d * d);
    acc_q = sum[48] ? knn_pkg::DistMax : sum[knn_pkg::DistW-1:0];
    if (b.row_last || b.set_last) begin
      j = near_cnt;
      while (j > 0 && acc_q < near_dist[j-1]) j--;
      if (j < NumNear) begin
        k = (near_cnt < NumNear) ? near_cnt : NumNear - 1;
        while (k > j) begin
          near_dist[k] = near_dist[k-1];
          near_lab[k] = near_lab[k-1];
          k--;
        end
        near_dist[j] = acc_q;
        near_lab[j] = b.label;
        if (near_cnt < NumNear) near_cnt++;
      end
      acc_q = '0;
    end
    if (b.set_last) begin
      class_q.push_back(vote_class());
      clear_near();
    end
  endfunction

  // Valid stays high between back-to-back beats; gap and wait_drain drop it.
  task automatic send(input knn_pkg::in_t b);
    in_valid_i <= 1'b1;
    in_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_beat(b);
    beats++;
  endtask

  task automatic gap();
    int unsigned n;
    n = ($urandom_range(3) == 0) ? $urandom_range(4) : 0;
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (class_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input knn_pkg::cfg_idx_e idx, input logic [knn_pkg::DistW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == knn_pkg::CfgThreshold) thr_q = data;
    else votes_q = data[knn_pkg::MinVotesW-1:0];
    @(posedge clk_i);
  endtask

  function automatic knn_pkg::in_t mk(input logic cmd, input int unsigned dim,
                                      input logic [15:0] val, input int unsigned lab,
                                      input logic rl, input logic sl);
    knn_pkg::in_t b;
    b.command = cmd;
    b.dim_index = knn_pkg::DimW'(dim);
    b.value = val;
    b.label = knn_pkg::LabelW'(lab);
    b.row_last = rl;
    b.set_last = sl;
    return b;
  endfunction

  task automatic load_query(input int unsigned dims, input bit extreme);
    for (int i = 0; i < dims; i++) begin
      send(mk(knn_pkg::CmdQuery, i, extreme ? 16'h8000 : 16'($urandom), $urandom, $urandom,
              $urandom));
      gap();
    end
  endtask

  // One reference set of random rows; dims never exceeds the written query.
  task automatic send_set(input int unsigned dims, input int unsigned rows, input int unsigned nlab);
    logic [15:0] v;
    logic [15:0] base;
    for (int r = 0; r < rows; r++) begin
      for (int i = 0; i < dims; i++) begin
        base = query_mem[i];
        case ($urandom_range(3))
          0: v = 16'($urandom);
          1: v = ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
          default: v = base + 16'($signed($urandom_range(64)) - 32);
        endcase
        send(mk(knn_pkg::CmdRef, i, v, $urandom_range(nlab - 1), i == dims - 1 && r != rows - 1,
                i == dims - 1 && r == rows - 1));
        gap();
      end
    end
  endtask

  typedef struct {
    knn_pkg::in_t beat;
    bit check;
    knn_pkg::out_t want;
  } row_stim_t;

  row_stim_t dir_tab[$];

  initial begin
    knn_pkg::out_t none;
    none = '{class_id: -11'sd1, score: '0, found: 1'b0};
    clear_near();
    for (int i = 0; i < NumDims; i++) query_mem[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: query writes at both dimension ends, lone sets, marks ignored on writes.
    dir_tab.push_back('{mk(knn_pkg::CmdQuery, 0, 16'h0000, 0, 1, 1), 0, none});
    dir_tab.push_back('{mk(knn_pkg::CmdQuery, 1, 16'h7FFF, 0, 1, 1), 0, none});
    dir_tab.push_back('{mk(knn_pkg::CmdQuery, 2047, 16'h8000, 1023, 0, 0), 0, none});
    dir_tab.push_back('{mk(knn_pkg::CmdRef, 0, 16'h0000, 5, 0, 1), 1, none});
    dir_tab.push_back('{mk(knn_pkg::CmdRef, 2047, 16'h8000, 7, 1, 0), 0, none});
    dir_tab.push_back('{mk(knn_pkg::CmdRef, 2047, 16'h8000, 7, 0, 1), 1,
                        '{class_id: 11'sd7, score: '0, found: 1'b1}});
    dir_tab.push_back('{mk(knn_pkg::CmdRef, 1, 16'h8000, 1023, 1, 0), 0, none});
    dir_tab.push_back('{mk(knn_pkg::CmdRef, 1, 16'h8000, 1023, 1, 0), 0, none});
    dir_tab.push_back('{mk(knn_pkg::CmdRef, 0, 16'h0000, 3, 1, 0), 0, none});
    dir_tab.push_back('{mk(knn_pkg::CmdRef, 0, 16'h0001, 3, 1, 0), 0, none});
    dir_tab.push_back('{mk(knn_pkg::CmdRef, 0, 16'h0002, 1, 1, 0), 0, none});
    dir_tab.push_back('{mk(knn_pkg::CmdRef, 0, 16'h0003, 1, 0, 1), 0, none});
    dir_tab.push_back('{mk(knn_pkg::CmdRef, 0, 16'hFFFF, 9, 0, 1), 0, none});
    foreach (dir_tab[i]) begin
      send(dir_tab[i].beat);
      if (dir_tab[i].check && class_q.size() != 0) class_q[$] = dir_tab[i].want;
    end
    wait_drain();

    write_reg(knn_pkg::CfgThreshold, knn_pkg::DistMax);
    write_reg(knn_pkg::CfgMinVotes, 3'd1);
    load_query(16, 1'b1);
    send_set(4, 3, 2);
    wait_drain();

    // Hold the output off while input keeps flowing so the block backs up.
    hold_off = 1'b1;
    load_query(8, 1'b0);
    for (int s = 0; s < 6; s++) send_set(1, 2, 3);
    wait_drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_reg(knn_pkg::CfgThreshold, '0);
        1: write_reg(knn_pkg::CfgThreshold, 48'($urandom_range(1 << 20)));
        2: write_reg(knn_pkg::CfgThreshold, knn_pkg::DistMax);
        default: write_reg(knn_pkg::CfgThreshold, {16'($urandom), 32'($urandom)});
      endcase
      write_reg(knn_pkg::CfgMinVotes, 3'(ph == 0 ? 0 : (ph == 1 ? 7 : $urandom_range(5, 1))));
      while (beats < 350 * (ph + 1)) begin
        if ($urandom_range(15) == 0) begin
          send(mk(knn_pkg::CmdQuery, $urandom_range(NumDims - 1), $urandom, $urandom, $urandom,
                  $urandom));
        end
        send_set($urandom_range(8, 1), $urandom_range(9, 1), $urandom_range(1, 0) ? 4 : 1024);
      end
      wait_drain();
    end

    $display("Covered %0d beats and %0d class decisions across six register settings.",
             beats, results);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stalls, plus a long counted stretch once hold_off is raised.
  always @(posedge clk_i) begin
    if (hold_off) begin
      hold_cnt = 300;
      hold_off = 1'b0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results++;
      if (class_q.size() == 0) begin
        report("unexpected beat", out_o, 0);
      end else begin
        knn_pkg::out_t w;
        w = class_q.pop_front();
        if (out_o.class_id !== w.class_id) report("class_id", out_o.class_id, w.class_id);
        if (out_o.score !== w.score) report("score", out_o.score, w.score);
        if (out_o.found !== w.found) report("found", out_o.found, w.found);
      end
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
